@@ design/obox_pkg.sv @@
package obox_pkg;

  // Geometry of the lanes
  localparam int DIMS_DEF  = 3;
  localparam int MAX_DIMS  = 3;
  localparam int CRD_W     = 16;
  localparam int PRD_W     = 2 * CRD_W;
  localparam int PRJ_W     = PRD_W + 2;
  localparam int DIF_W     = PRJ_W + 1;
  localparam int SHIFT     = 25;
  localparam int NUM_W     = DIF_W + SHIFT;
  localparam int DEN_W     = PRJ_W;
  localparam int QUO_W     = 32;
  localparam int RES_W     = 32;

  // Register stages in one lane: four ahead of the divider, the divider itself,
  // one for saturation and ordering
  localparam int DIV_LAT   = QUO_W + 1;
  localparam int LANE_LAT  = 4 + DIV_LAT + 1;

  // Configuration port
  localparam int CFG_W     = 3 * CRD_W;
  localparam int CIDX_W    = 3;
  localparam logic [CIDX_W-1:0] REG_BOX_MIN = 3'd0;
  localparam logic [CIDX_W-1:0] REG_BOX_MAX = 3'd1;
  localparam logic [CIDX_W-1:0] REG_ROT_0   = 3'd2;
  localparam logic [CIDX_W-1:0] REG_ROT_1   = 3'd3;
  localparam logic [CIDX_W-1:0] REG_ROT_2   = 3'd4;

  localparam logic [CFG_W-1:0] ROT_0_RST = 48'h0000_0000_4000;
  localparam logic [CFG_W-1:0] ROT_1_RST = 48'h0000_4000_0000;
  localparam logic [CFG_W-1:0] ROT_2_RST = 48'h4000_0000_0000;

  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};

  typedef logic signed [CRD_W-1:0] crd_t;

  // Slab result of one axis
  typedef struct packed {
    logic                    in_slab;
    logic                    dzero;
    logic signed [RES_W-1:0] t_lo;
    logic signed [RES_W-1:0] t_hi;
  } lane_res_t;

endpackage

@@ design/obox_div.sv @@
module obox_div
  import obox_pkg::*;
#(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W,
  parameter int QW = QUO_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg,
  output logic [QW-1:0] quo,
  output logic          ovf,
  output logic          neg_o
);

  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] den_r [QW+1];
  logic [QW-1:0] low_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic          neg_r [QW+1];

  // Take the top bits as first remainder; flag quotients that need more than QW bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(num[NW-1:QW]);
      den_r[0] <= den;
      low_r[0] <= num[QW-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= DW'(num[NW-1:QW]) >= den;
      neg_r[0] <= neg;
    end
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;
    assign trial = {rem_r[k-1], low_r[k-1][QW-1]};
    assign ge    = trial >= {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? DW'(trial - {1'b0, den_r[k-1]}) : DW'(trial);
        den_r[k] <= den_r[k-1];
        low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][QW-2:0], ge};
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  assign quo   = q_r[QW];
  assign ovf   = ovf_r[QW];
  assign neg_o = neg_r[QW];

endmodule

@@ design/obox_lane.sv @@
module obox_lane
  import obox_pkg::*;
#(
  parameter int DIMS = DIMS_DEF
) (
  input  logic      clk,
  input  logic      en,
  input  crd_t      org  [MAX_DIMS],
  input  crd_t      dir  [MAX_DIMS],
  input  crd_t      bmin [MAX_DIMS],
  input  crd_t      bmax [MAX_DIMS],
  input  crd_t      col  [MAX_DIMS],
  output lane_res_t res
);

  logic signed [PRD_W-1:0] po_r [MAX_DIMS];
  logic signed [PRD_W-1:0] pd_r [MAX_DIMS];
  logic signed [PRD_W-1:0] pn_r [MAX_DIMS];
  logic signed [PRD_W-1:0] px_r [MAX_DIMS];

  logic signed [PRJ_W-1:0] ro_r, rd_r, rn_r, rx_r;
  logic signed [PRJ_W-1:0] ro_nxt, rd_nxt, rn_nxt, rx_nxt;

  logic signed [DIF_W-1:0] dlo_r, dhi_r;
  logic signed [PRJ_W-1:0] rd3_r;
  logic                    inside3_r, dzero3_r;

  logic [NUM_W-1:0] nlo_r, nhi_r;
  logic [DEN_W-1:0] dmag_r;
  logic             neglo_r, neghi_r, inside4_r, dzero4_r;

  logic             inside_d_r [DIV_LAT];
  logic             dzero_d_r  [DIV_LAT];

  logic [QUO_W-1:0] qlo, qhi;
  logic             ovflo, ovfhi, nlo_o, nhi_o;
  logic signed [RES_W-1:0] slo, shi;

  // Multiply each component by its matrix entry
  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < MAX_DIMS; r++) begin
        if (r < DIMS) begin
          po_r[r] <= col[r] * org[r];
          pd_r[r] <= col[r] * dir[r];
          pn_r[r] <= col[r] * bmin[r];
          px_r[r] <= col[r] * bmax[r];
        end else begin
          po_r[r] <= '0;
          pd_r[r] <= '0;
          pn_r[r] <= '0;
          px_r[r] <= '0;
        end
      end
    end
  end

  // Sum the products into the projected components
  always_comb begin
    ro_nxt = '0;
    rd_nxt = '0;
    rn_nxt = '0;
    rx_nxt = '0;
    for (int r = 0; r < MAX_DIMS; r++) begin
      ro_nxt = ro_nxt + PRJ_W'(po_r[r]);
      rd_nxt = rd_nxt + PRJ_W'(pd_r[r]);
      rn_nxt = rn_nxt + PRJ_W'(pn_r[r]);
      rx_nxt = rx_nxt + PRJ_W'(px_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ro_r <= ro_nxt;
      rd_r <= rd_nxt;
      rn_r <= rn_nxt;
      rx_r <= rx_nxt;
    end
  end

  // Order the corners, test the origin against the slab, form the distances
  always_ff @(posedge clk) begin
    if (en) begin
      inside3_r <= (ro_r >= rn_r && ro_r <= rx_r) || (ro_r >= rx_r && ro_r <= rn_r);
      dzero3_r  <= rd_r == '0;
      rd3_r     <= rd_r;
      if (rn_r > rx_r) begin
        dlo_r <= DIF_W'(rx_r) - DIF_W'(ro_r);
        dhi_r <= DIF_W'(rn_r) - DIF_W'(ro_r);
      end else begin
        dlo_r <= DIF_W'(rn_r) - DIF_W'(ro_r);
        dhi_r <= DIF_W'(rx_r) - DIF_W'(ro_r);
      end
    end
  end

  // Split into magnitude and sign for the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      nlo_r     <= {(dlo_r[DIF_W-1] ? DIF_W'(-dlo_r) : DIF_W'(dlo_r)), {SHIFT{1'b0}}};
      nhi_r     <= {(dhi_r[DIF_W-1] ? DIF_W'(-dhi_r) : DIF_W'(dhi_r)), {SHIFT{1'b0}}};
      dmag_r    <= rd3_r[PRJ_W-1] ? DEN_W'(-rd3_r) : DEN_W'(rd3_r);
      neglo_r   <= dlo_r[DIF_W-1] ^ rd3_r[PRJ_W-1];
      neghi_r   <= dhi_r[DIF_W-1] ^ rd3_r[PRJ_W-1];
      inside4_r <= inside3_r;
      dzero4_r  <= dzero3_r;
    end
  end

  obox_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_lo (
    .clk(clk), .en(en), .num(nlo_r), .den(dmag_r), .neg(neglo_r),
    .quo(qlo), .ovf(ovflo), .neg_o(nlo_o)
  );

  obox_div #(.NW(NUM_W), .DW(DEN_W), .QW(QUO_W)) u_div_hi (
    .clk(clk), .en(en), .num(nhi_r), .den(dmag_r), .neg(neghi_r),
    .quo(qhi), .ovf(ovfhi), .neg_o(nhi_o)
  );

  // Carry the slab flags alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      inside_d_r[0] <= inside4_r;
      dzero_d_r[0]  <= dzero4_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        inside_d_r[k] <= inside_d_r[k-1];
        dzero_d_r[k]  <= dzero_d_r[k-1];
      end
    end
  end

  // Saturate the signed quotients to the result range
  always_comb begin
    if (ovflo) begin
      slo = nlo_o ? RES_MIN : RES_MAX;
    end else if (nlo_o) begin
      slo = (qlo[QUO_W-1] && |qlo[QUO_W-2:0]) ? RES_MIN : RES_W'(-qlo);
    end else begin
      slo = qlo[QUO_W-1] ? RES_MAX : RES_W'(qlo);
    end
    if (ovfhi) begin
      shi = nhi_o ? RES_MIN : RES_MAX;
    end else if (nhi_o) begin
      shi = (qhi[QUO_W-1] && |qhi[QUO_W-2:0]) ? RES_MIN : RES_W'(-qhi);
    end else begin
      shi = qhi[QUO_W-1] ? RES_MAX : RES_W'(qhi);
    end
  end

  // Put entry before exit
  always_ff @(posedge clk) begin
    if (en) begin
      res.in_slab <= inside_d_r[DIV_LAT-1];
      res.dzero   <= dzero_d_r[DIV_LAT-1];
      res.t_lo    <= (slo > shi) ? shi : slo;
      res.t_hi    <= (slo > shi) ? slo : shi;
    end
  end

endmodule

@@ design/obox_merge.sv @@
module obox_merge
  import obox_pkg::*;
#(
  parameter int DIMS = DIMS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld,
  input  logic                    op,
  input  lane_res_t               lres [MAX_DIMS],
  output logic                    out_valid,
  output logic                    hit,
  output logic signed [RES_W-1:0] near_dist,
  output logic signed [RES_W-1:0] far_dist
);

  logic signed [RES_W-1:0] near_c, far_c;
  logic                    ok_c, allin_c, hit_c;
  logic                    valid_r, hit_r;
  logic signed [RES_W-1:0] near_r, far_r;

  // Intersect the slabs of all lanes
  always_comb begin
    near_c  = RES_MIN;
    far_c   = RES_MAX;
    ok_c    = 1'b1;
    allin_c = 1'b1;
    for (int i = 0; i < DIMS; i++) begin
      allin_c = allin_c & lres[i].in_slab;
      if (lres[i].dzero) begin
        ok_c = ok_c & lres[i].in_slab;
      end else begin
        if (lres[i].t_lo > near_c) near_c = lres[i].t_lo;
        if (lres[i].t_hi < far_c)  far_c  = lres[i].t_hi;
      end
    end
    hit_c = op ? allin_c : (ok_c && near_c <= far_c && !far_c[RES_W-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= vld;
    end
  end

  // Hold the result until it is taken; zero distances on a miss or a point test
  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= hit_c;
      near_r <= (hit_c && !op) ? near_c : '0;
      far_r  <= (hit_c && !op) ? far_c : '0;
    end
  end

  assign out_valid = valid_r;
  assign hit       = hit_r;
  assign near_dist = near_r;
  assign far_dist  = far_r;

endmodule

@@ design/oriented_box_ray_slab_test.sv @@
// Oriented box ray and point test.
// Requests arrive on the in_ stream: tuser is the opcode (0 ray slab test,
// 1 point-inside test), tdata the origin and direction. Each accepted request
// gives exactly one result on the out_ stream: tuser is the hit flag, tdata
// the entry and exit parameters (zero on a miss or a point test).
// One axis is handled per lane: projection onto the box frame, two pipelined
// restoring dividers of one quotient bit per stage, and saturation. A merge
// stage intersects the slabs and drives the output register.
// One request is taken per cycle, back to back, unless the receiver stalls.
// When the receiver stalls the whole pipeline holds and in_tready drops while
// a result waits; in_tready is high whenever the output register is empty or
// being read. Reset empties the pipeline and loads the identity matrix and a
// zero box. Write the configuration only while no request is in flight.
module oriented_box_ray_slab_test
  import obox_pkg::*;
#(
  parameter int DIMS = DIMS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [95:0]       in_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  input  logic              in_tuser,   // opcode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [63:0]       out_tdata,  // near_dist, far_dist
  output logic              out_tuser,  // hit
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] box_min_r, box_max_r;
  logic [CFG_W-1:0] rot_r [MAX_DIMS];
  logic             en;
  logic             vld_r [LANE_LAT];
  logic             op_r  [LANE_LAT];
  crd_t             org [MAX_DIMS];
  crd_t             dir [MAX_DIMS];
  crd_t             bmin [MAX_DIMS];
  crd_t             bmax [MAX_DIMS];
  lane_res_t        lres [MAX_DIMS];
  logic signed [RES_W-1:0] near_d, far_d;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= '0;
      box_max_r <= '0;
      rot_r[0]  <= ROT_0_RST;
      rot_r[1]  <= ROT_1_RST;
      rot_r[2]  <= ROT_2_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BOX_MIN: box_min_r <= cfg_data;
        REG_BOX_MAX: box_max_r <= cfg_data;
        REG_ROT_0:   rot_r[0]  <= cfg_data;
        REG_ROT_1:   rot_r[1]  <= cfg_data;
        REG_ROT_2:   rot_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance whenever the output register is free or being read
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      org[k]  = in_tdata[CRD_W*k +: CRD_W];
      dir[k]  = in_tdata[CRD_W*(MAX_DIMS+k) +: CRD_W];
      bmin[k] = box_min_r[CRD_W*k +: CRD_W];
      bmax[k] = box_max_r[CRD_W*k +: CRD_W];
    end
  end

  // Request tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LANE_LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < LANE_LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0] <= in_tuser;
      for (int k = 1; k < LANE_LAT; k++) op_r[k] <= op_r[k-1];
    end
  end

  for (genvar i = 0; i < MAX_DIMS; i++) begin : g_lane
    if (i < DIMS) begin : g_on
      crd_t col [MAX_DIMS];
      always_comb begin
        for (int r = 0; r < MAX_DIMS; r++) col[r] = rot_r[r][CRD_W*i +: CRD_W];
      end
      obox_lane #(.DIMS(DIMS)) u_lane (
        .clk(clk), .en(en), .org(org), .dir(dir), .bmin(bmin), .bmax(bmax),
        .col(col), .res(lres[i])
      );
    end else begin : g_off
      assign lres[i] = '0;
    end
  end

  obox_merge #(.DIMS(DIMS)) u_merge (
    .clk(clk), .rst_n(rst_n), .en(en), .vld(vld_r[LANE_LAT-1]), .op(op_r[LANE_LAT-1]),
    .lres(lres), .out_valid(out_tvalid), .hit(out_tuser), .near_dist(near_d),
    .far_dist(far_d)
  );

  assign out_tdata = {far_d, near_d};

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r[LANE_LAT-1]) && $stable(vld_r[0]))
    else $error("pipeline moved during a stall");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !(out_tvalid && !out_tready))
    else $error("request taken while a result is blocked");
  a_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[LANE_LAT-1] && op_r[LANE_LAT-1] |=> out_tdata == '0)
    else $error("point test returned distances");
  a_ray_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> $signed(near_d) <= $signed(far_d) && !far_d[RES_W-1])
    else $error("hit with inverted or negative interval");
`endif

endmodule

@@ tb/sv/obox_checker.sv @@
`timescale 1ns / 100ps

// Watches both streams and the configuration port, predicts each result and
// compares it with what the block returns.
module obox_checker
  import obox_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [95:0]       in_tdata,
  input  logic              in_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [63:0]       out_tdata,
  input  logic              out_tuser,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                fail_count,
  output int                pending,
  output int                hits_seen,
  output int                results_seen
);

  typedef struct packed {
    logic                    hit;
    logic signed [RES_W-1:0] near_t;
    logic signed [RES_W-1:0] far_t;
  } slab_res_t;

  logic [CFG_W-1:0] box_lo, box_hi, row [3];
  slab_res_t        expected_q [$];

  function automatic longint crd(logic [CFG_W-1:0] v, int k);
    crd_t c;
    c = v[16*k +: 16];
    return longint'(c);
  endfunction

  function automatic longint sat(longint x);
    if (x > longint'(RES_MAX)) return longint'(RES_MAX);
    if (x < longint'(RES_MIN)) return longint'(RES_MIN);
    return x;
  endfunction

  // Project a vector into the box frame: component i sums M[r][i] * v[r]
  function automatic void to_box_frame(input longint v [3], output longint p [3]);
    for (int i = 0; i < 3; i++) begin
      p[i] = 0;
      for (int r = 0; r < 3; r++) p[i] += crd(row[r], i) * v[r];
    end
  endfunction

  function automatic slab_res_t predict_slab(logic op, logic [95:0] d);
    longint o [3], dv [3], a [3], b [3], po [3], pd [3], pa [3], pb [3];
    longint nr, fr, t1, t2, tmp;
    logic hit;
    slab_res_t r;
    nr = longint'(RES_MIN);
    fr = longint'(RES_MAX);
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      o[i]  = crd(d[47:0], i);
      dv[i] = crd(d[95:48], i);
      a[i]  = crd(box_lo, i);
      b[i]  = crd(box_hi, i);
    end
    to_box_frame(o, po);
    to_box_frame(dv, pd);
    to_box_frame(a, pa);
    to_box_frame(b, pb);
    for (int i = 0; i < 3; i++)
      if (pa[i] > pb[i]) begin
        tmp = pa[i]; pa[i] = pb[i]; pb[i] = tmp;
      end
    r = '0;
    if (op) begin
      for (int i = 0; i < 3; i++)
        if (po[i] < pa[i] || po[i] > pb[i]) hit = 1'b0;
      r.hit = hit;
      return r;
    end
    for (int i = 0; i < 3 && hit; i++) begin
      if (pd[i] == 0) begin
        if (po[i] < pa[i] || po[i] > pb[i]) hit = 1'b0;
        continue;
      end
      t1 = sat(((pa[i] - po[i]) * (64'sd1 <<< SHIFT)) / pd[i]);
      t2 = sat(((pb[i] - po[i]) * (64'sd1 <<< SHIFT)) / pd[i]);
      if (t1 > t2) begin
        tmp = t1; t1 = t2; t2 = tmp;
      end
      if (t1 > nr) nr = t1;
      if (t2 < fr) fr = t2;
      if (nr > fr || fr < 0) hit = 1'b0;
    end
    if (hit) begin
      r.hit = 1'b1;
      r.near_t = nr[31:0];
      r.far_t = fr[31:0];
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    slab_res_t e;
    if (!rst_n) begin
      box_lo <= '0;
      box_hi <= '0;
      row[0] <= ROT_0_RST;
      row[1] <= ROT_1_RST;
      row[2] <= ROT_2_RST;
      fail_count <= 0;
      hits_seen <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      // Track register writes
      if (cfg_we) begin
        case (cfg_idx)
          REG_BOX_MIN: box_lo <= cfg_data;
          REG_BOX_MAX: box_hi <= cfg_data;
          REG_ROT_0:   row[0] <= cfg_data;
          REG_ROT_1:   row[1] <= cfg_data;
          REG_ROT_2:   row[2] <= cfg_data;
          default: ;
        endcase
      end
      // Queue the prediction for each accepted request
      if (in_tvalid && in_tready) expected_q.push_back(predict_slab(in_tuser, in_tdata));
      // Compare each accepted result with the oldest prediction
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (out_tuser) hits_seen <= hits_seen + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result hit=%b data=%h", $time, out_tuser, out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.hit !== out_tuser || e.near_t !== out_tdata[31:0]
              || e.far_t !== out_tdata[63:32]) begin
            $display("%0t: expected hit=%b near=%0d far=%0d, got hit=%b near=%0d far=%0d",
                     $time, e.hit, e.near_t, e.far_t, out_tuser,
                     $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import obox_pkg::*;

  localparam int LATENCY = 39;
  localparam int WATCHDOG = 5000;
  localparam logic OP_RAY = 1'b0;
  localparam logic OP_POINT = 1'b1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [95:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [63:0]       out_tdata;
  logic              out_tuser;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_idx = REG_BOX_MIN;
  logic [CFG_W-1:0]  cfg_data = '0;

  int fail_count, pending, hits_seen, results_seen;
  int idle_cycles = 0;
  int requests_sent = 0;
  bit long_hold = 1'b0;
  bit no_stall = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  oriented_box_ray_slab_test uut (.*);

  obox_checker chk (.*);

  // Receiver: random stalls, one phase with no stalls, and one long hold
  always @(posedge clk) begin
    if (long_hold) out_tready <= 1'b0;
    else if (no_stall) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // Watchdog on cycles with no accepted request or result, register write or long hold
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || long_hold)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("oriented_box_ray_slab_test: mismatch");
      $finish;
    end
  end

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  // Write one register; the write enable drops with the next request
  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  // Drain everything, then let the pipeline settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted
  task automatic send_request(logic op, logic [95:0] d);
    cfg_we <= 1'b0;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic idle_gap(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rnd_crd();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rnd_dir();
    case ($urandom_range(0, 6))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random matrix row: mostly near unit values, sometimes anything
  function automatic logic [47:0] rnd_row(int k);
    logic [47:0] r;
    r = '0;
    if ($urandom_range(0, 2) == 0) r = 48'({$urandom, $urandom});
    else r[16*k +: 16] = ($urandom_range(0, 1) ? 16'h4000 : 16'hc000);
    if ($urandom_range(0, 3) == 0) r[16*$urandom_range(0, 2) +: 16] = 16'($urandom);
    return r;
  endfunction

  // Random request: a ray or a point test, with the origin near the box much of the time
  task automatic send_random(int lo, int hi);
    logic [95:0] d;
    logic op;
    op = ($urandom_range(0, 3) == 0) ? OP_POINT : OP_RAY;
    if ($urandom_range(0, 1))
      d = {rnd_dir(), rnd_dir(), rnd_dir(),
           pack3($urandom_range(0, hi - lo) + lo, $urandom_range(0, hi - lo) + lo,
                 $urandom_range(0, hi - lo) + lo)};
    else d = {rnd_dir(), rnd_dir(), rnd_dir(), rnd_crd(), rnd_crd(), rnd_crd()};
    send_request(op, d);
  endtask

  initial begin
    int lo, hi;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset configuration, zero box
    send_request(OP_POINT, '0);
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h4000, 48'h0});
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h0000, 48'h0});
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h0000, pack3(1, 0, 0)});
    idle_gap(0);
    drain();

    // Directed: axis-aligned box, rays through, beside, away and inside, and point tests
    write_reg(REG_BOX_MIN, pack3(-160, -160, -160));
    write_reg(REG_BOX_MAX, pack3(160, 160, 160));
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h4000, pack3(-800, 0, 0)});
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'hc000, pack3(-800, 0, 0)});
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h4000, pack3(-800, 500, 0)});
    send_request(OP_RAY, {16'h2000, 16'h2000, 16'h2000, pack3(0, 0, 0)});
    send_request(OP_RAY, {16'h0001, 16'h0001, 16'h0001, pack3(-32768, -32768, -32768)});
    send_request(OP_RAY, {16'h8000, 16'h7fff, 16'h8000, pack3(32767, -32768, 32767)});
    send_request(OP_RAY, {16'hffff, 16'hffff, 16'hffff, pack3(32767, 32767, 32767)});
    send_request(OP_POINT, {48'hffff_ffff_ffff, pack3(160, 160, 160)});
    send_request(OP_POINT, {48'h0, pack3(161, 0, 0)});
    send_request(OP_POINT, {48'h0, pack3(-32768, 32767, 0)});
    idle_gap(0);
    drain();

    // Directed: corners given reversed, extreme matrix entries
    write_reg(REG_BOX_MIN, pack3(32767, 32767, 32767));
    write_reg(REG_BOX_MAX, pack3(-32768, -32768, -32768));
    write_reg(REG_ROT_0, 48'h8000_8000_8000);
    write_reg(REG_ROT_1, 48'h7fff_7fff_7fff);
    write_reg(REG_ROT_2, 48'h8000_0000_7fff);
    send_request(OP_RAY, {16'h7fff, 16'h8000, 16'h0001, pack3(0, 0, 0)});
    send_request(OP_RAY, {16'h0000, 16'h0000, 16'h0000, pack3(100, -100, 5)});
    send_request(OP_POINT, {48'h0, pack3(32767, 32767, 32767)});
    send_request(OP_POINT, {48'h0, pack3(-32768, -32768, -32768)});
    send_request(OP_RAY, {16'h8000, 16'h8000, 16'h8000, pack3(-32768, -32768, -32768)});
    idle_gap(0);
    drain();

    // Random phases with fresh configurations
    for (int ph = 0; ph < 10; ph++) begin
      lo = -$urandom_range(1, 2000);
      hi = $urandom_range(1, 2000);
      write_reg(REG_BOX_MIN, ph == 9 ? 48'({$urandom, $urandom}) : pack3(lo, lo, lo));
      write_reg(REG_BOX_MAX, ph == 9 ? 48'({$urandom, $urandom}) : pack3(hi, hi, hi));
      write_reg(REG_ROT_0, ph == 0 ? ROT_0_RST : rnd_row(0));
      write_reg(REG_ROT_1, ph == 0 ? ROT_1_RST : rnd_row(1));
      write_reg(REG_ROT_2, ph == 0 ? ROT_2_RST : rnd_row(2));
      no_stall = (ph == 3);
      for (int n = 0; n < 150;) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 150; b++, n++) begin
          send_random(lo * 2, hi * 2);
          // Long receiver hold while requests keep coming
          if (ph == 5 && n == 20) fork
            begin
              long_hold = 1'b1;
              repeat (150) @(posedge clk);
              long_hold = 1'b0;
            end
          join_none
        end
        if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 12));
      end
      idle_gap(0);
      drain();
    end

    $display("Sent %0d requests over 13 configurations; %0d of %0d results were hits.",
             requests_sent, hits_seen, results_seen);
    if (fail_count == 0) $display("oriented_box_ray_slab_test: match");
    else $display("oriented_box_ray_slab_test: mismatch");
    $finish;
  end

endmodule
